// ----- src/lba_pkg.sv -----
// Shared constants and types for the linked block allocator.
package lba_pkg;

    // Default sizing of the block pool and the file directory.
    localparam int LBA_NUM_BLOCKS  = 64;
    localparam int LBA_DIR_ENTRIES = 16;

    // Fixed field widths of the ports.
    localparam int CFG_W     = 7;
    localparam int KEY_W     = 64;
    localparam int SIZE_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    // Operation codes carried by func.
    localparam logic FUNC_CREATE = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_DIRFULL  = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

endpackage

// ----- src/lba_ram.sv -----
// Simple dual-port memory with one write port and one registered read port.
module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share the clock; contents have no reset.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/linked_block_allocator_unit.sv -----
// Top level of the linked block allocator: sequencer, block flags and directory control.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one word per operation: func selects
//   create or delete, file_key names the file and file_blocks gives the size of a create.
//   The output channel (out_valid/out_ready) returns one word per operation with status,
//   first_block, last_block and free_left.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number of managed
//   blocks; a write frees every block and empties the directory. It is taken only while
//   the sequencer is idle and has priority over a waiting input word.
// Operation flow:
//   One operation at a time. An error found in the check step goes straight to the done
//   step. A create scans block indices upward from zero and claims free blocks until the
//   last one is claimed. A delete searches the directory, frees each block of the chain
//   and moves later entries down to close the gap; a missing name is looked for in every
//   directory entry. The next word is taken in the cycle after the result is loaded at the
//   earliest.
// Reset and stalls:
//   Reset frees all NUM_BLOCKS blocks and empties the directory; no clearing pass is
//   needed. A finished result waits in the output register while the next word is
//   accepted; a later result waits in the done step until the register is taken.
module linked_block_allocator_unit #(
    parameter int NUM_BLOCKS  = lba_pkg::LBA_NUM_BLOCKS,
    parameter int DIR_ENTRIES = lba_pkg::LBA_DIR_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lba_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [lba_pkg::KEY_W-1:0]      file_key,
    input  logic [lba_pkg::SIZE_W-1:0]     file_blocks,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lba_pkg::STATUS_W-1:0]   status,
    output logic [lba_pkg::IDX_OUT_W-1:0]  first_block,
    output logic [lba_pkg::IDX_OUT_W-1:0]  last_block,
    output logic [lba_pkg::CNT_OUT_W-1:0]  free_left
);

    import lba_pkg::*;

    localparam int BW         = $clog2(NUM_BLOCKS);
    localparam int FW         = $clog2(NUM_BLOCKS + 1);
    localparam int CW         = (FW > SIZE_W) ? FW : SIZE_W;
    localparam int DW         = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int EW         = $clog2(DIR_ENTRIES + 1);
    localparam int DIR_WORD_W = KEY_W + BW;

    localparam logic [CW-1:0] BLOCK_LIMIT = CW'(NUM_BLOCKS);
    localparam logic [EW-1:0] DIR_LIMIT   = EW'(DIR_ENTRIES);
    localparam logic [FW-1:0] FREE_RESET  = FW'(NUM_BLOCKS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // Block index to the 6-bit output field.
    function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [BW-1:0] v);
        logic [BW+IDX_OUT_W-1:0] ext;
        ext = {{IDX_OUT_W{1'b0}}, v};
        return ext[IDX_OUT_W-1:0];
    endfunction

    // Free count to the 7-bit output field.
    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [FW-1:0] v);
        logic [FW+CNT_OUT_W-1:0] ext;
        ext = {{CNT_OUT_W{1'b0}}, v};
        return ext[CNT_OUT_W-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic                   func_reg, func_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [SIZE_W-1:0]      left_reg, left_next;
    logic [FW-1:0]          free_reg, free_next;
    logic [EW-1:0]          entry_cnt_reg, entry_cnt_next;
    logic [EW-1:0]          ent_reg, ent_next;
    logic [BW-1:0]          scan_reg, scan_next;
    logic [BW-1:0]          head_reg, head_next;
    logic [BW-1:0]          prev_reg, prev_next;
    logic [BW-1:0]          pos_reg, pos_next;
    logic [NUM_BLOCKS-1:0]  busy_reg, busy_next;
    logic [NUM_BLOCKS-1:0]  final_reg, final_next;
    status_t                res_status_reg, res_status_next;
    logic [BW-1:0]          res_first_reg, res_first_next;
    logic [BW-1:0]          res_last_reg, res_last_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [IDX_OUT_W-1:0]   out_first_reg, out_first_next;
    logic [IDX_OUT_W-1:0]   out_last_reg, out_last_next;
    logic [CNT_OUT_W-1:0]   out_free_reg, out_free_next;

    logic                   link_we;
    logic [BW-1:0]          link_waddr, link_wdata, link_raddr, link_rdata;
    logic                   dir_we;
    logic [DW-1:0]          dir_waddr, dir_raddr;
    logic [DIR_WORD_W-1:0]  dir_wdata, dir_rdata;

    logic [CW-1:0]          cfg_ext, cfg_clamped;
    logic [EW:0]            ent_plus1, ent_plus2;
    logic                   first_claim;
    logic [BW-1:0]          chain_head;
    logic                   shift_end;

    // Link memory: next block of each chain.
    lba_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_BLOCKS),
        .AW    (BW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Directory memory: file key and first block per entry.
    lba_ram #(
        .WIDTH (DIR_WORD_W),
        .DEPTH (DIR_ENTRIES),
        .AW    (DW)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    // Handshakes: configuration wins over a waiting input word.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    // Clamp the written block count into the supported range.
    always_comb
    begin
        cfg_ext = CW'(cfg_data);
        if (cfg_ext == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (cfg_ext > BLOCK_LIMIT)
        begin
            cfg_clamped = BLOCK_LIMIT;
        end
        else
        begin
            cfg_clamped = cfg_ext;
        end
    end

    // Directory addresses one and two entries ahead of the current one.
    assign ent_plus1   = {1'b0, ent_reg} + (EW + 1)'(1);
    assign ent_plus2   = {1'b0, ent_reg} + (EW + 1)'(2);
    assign first_claim = (left_reg == size_reg);
    assign chain_head  = first_claim ? scan_reg : head_reg;
    assign shift_end   = (ent_plus1 >= {1'b0, entry_cnt_reg});

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        left_next       = left_reg;
        free_next       = free_reg;
        entry_cnt_next  = entry_cnt_reg;
        ent_next        = ent_reg;
        scan_next       = scan_reg;
        head_next       = head_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        busy_next       = busy_reg;
        final_next      = final_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_free_next   = out_free_reg;
        link_we         = 1'b0;
        link_waddr      = prev_reg;
        link_wdata      = scan_reg;
        link_raddr      = pos_reg;
        dir_we          = 1'b0;
        dir_waddr       = entry_cnt_reg[DW-1:0];
        dir_wdata       = {key_reg, chain_head};
        dir_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    free_next      = cfg_clamped[FW-1:0];
                    entry_cnt_next = '0;
                    busy_next      = '0;
                    final_next     = '0;
                end
                else if (in_valid)
                begin
                    func_next  = func;
                    key_next   = file_key;
                    size_next  = file_blocks;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_first_next = '0;
                res_last_next  = '0;
                ent_next       = '0;
                if (func_reg == FUNC_CREATE)
                begin
                    if (size_reg == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (CW'(size_reg) > CW'(free_reg))
                    begin
                        res_status_next = ST_NOMEM;
                        state_next      = S_DONE;
                    end
                    else if (entry_cnt_reg == DIR_LIMIT)
                    begin
                        res_status_next = ST_DIRFULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        scan_next  = '0;
                        left_next  = size_reg;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end

            // Claim the lowest free blocks, one block index per cycle.
            S_SCAN:
            begin
                scan_next = scan_reg + BW'(1);
                if (!busy_reg[scan_reg])
                begin
                    busy_next[scan_reg]  = 1'b1;
                    final_next[scan_reg] = (left_reg == SIZE_W'(1));
                    free_next            = free_reg - FW'(1);
                    left_next            = left_reg - SIZE_W'(1);
                    prev_next            = scan_reg;
                    if (first_claim)
                    begin
                        head_next = scan_reg;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    if (left_reg == SIZE_W'(1))
                    begin
                        dir_we          = 1'b1;
                        entry_cnt_next  = entry_cnt_reg + EW'(1);
                        res_status_next = ST_OK;
                        res_first_next  = chain_head;
                        res_last_next   = scan_reg;
                        state_next      = S_DONE;
                    end
                end
            end

            // Compare one directory entry per cycle; the read runs one entry ahead.
            S_SEARCH:
            begin
                dir_raddr = ent_plus1[DW-1:0];
                if (ent_reg >= entry_cnt_reg)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
                else if (dir_rdata[DIR_WORD_W-1 -: KEY_W] == key_reg)
                begin
                    pos_next        = dir_rdata[BW-1:0];
                    link_raddr      = dir_rdata[BW-1:0];
                    res_status_next = ST_OK;
                    res_first_next  = dir_rdata[BW-1:0];
                    state_next      = S_WALK;
                end
                else
                begin
                    ent_next = ent_plus1[EW-1:0];
                end
            end

            // Free one block of the chain per cycle. A freed block is no longer
            // busy, so the walk cannot come around a loop.
            S_WALK:
            begin
                dir_raddr  = ent_plus1[DW-1:0];
                link_raddr = link_rdata;
                if (!busy_reg[pos_reg])
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    busy_next[pos_reg]  = 1'b0;
                    final_next[pos_reg] = 1'b0;
                    free_next           = free_reg + FW'(1);
                    if (final_reg[pos_reg])
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        pos_next = link_rdata;
                    end
                end
            end

            // Move later entries down by one to close the gap.
            S_SHIFT:
            begin
                dir_raddr = ent_plus2[DW-1:0];
                if (shift_end)
                begin
                    entry_cnt_next = entry_cnt_reg - EW'(1);
                    state_next     = S_DONE;
                end
                else
                begin
                    dir_we    = 1'b1;
                    dir_waddr = ent_reg[DW-1:0];
                    dir_wdata = dir_rdata;
                    ent_next  = ent_plus1[EW-1:0];
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_first_next  = idx_out(res_first_reg);
                    out_last_next   = idx_out(res_last_reg);
                    out_free_next   = cnt_out(free_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= FREE_RESET;
            entry_cnt_reg <= '0;
            busy_reg      <= '0;
            final_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            entry_cnt_reg <= entry_cnt_next;
            busy_reg      <= busy_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        left_reg       <= left_next;
        ent_reg        <= ent_next;
        scan_reg       <= scan_next;
        head_reg       <= head_next;
        prev_reg       <= prev_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
        out_free_reg   <= out_free_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign first_block = out_first_reg;
    assign last_block  = out_last_reg;
    assign free_left   = out_free_reg;

    // The free count never exceeds the pool size.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_RESET)
    else $error("free count above pool size");

    // A scan always has blocks left to claim.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (left_reg != '0))
    else $error("block scan running with nothing left to claim");

    // Closing the directory gap removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && shift_end
        |=> entry_cnt_reg == EW'($past(entry_cnt_reg) - 1'b1))
    else $error("delete did not remove one directory entry");

    // An accepted word keeps the input closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input open while an operation is running");

    // A finished result with a free output register is delivered at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (!out_valid_reg || out_ready)
        |=> out_valid_reg && (state_reg == S_IDLE))
    else $error("finished result not moved to the output register");

endmodule
